// ===== rtl/odo_pkg.sv =====
`timescale 1ns / 1ps
package odo_pkg;

    localparam int FRAC_BITS_DEF   = 16;
    localparam int COUNT_WIDTH_DEF = 32;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 20;
    localparam logic [CFG_IDX_W-1:0] REG_COUNTS_PER_REV    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WHEEL_DIAMETER_UM = 1'd1;
    localparam logic [15:0] CPR_RESET  = 16'd910;
    localparam logic [19:0] DIAM_RESET = 20'd67000;

    localparam int WORD_W = 32;
    localparam int HEAD_W = 13;
    localparam int Q30    = 30;
    localparam logic [WORD_W-1:0] PI_Q30 = 32'd3373259426;
    localparam int DEN_W  = 58;
    localparam int QUO_W  = 34;
    localparam logic [QUO_W-1:0] SAT_MAG = 34'h2_0000_0000;

    localparam int RX_W        = 41;
    localparam int RECIP_SHIFT = 48;
    localparam logic [WORD_W-1:0] RECIP_LO = 32'd1236950582;
    localparam logic [WORD_W-1:0] RECIP_HI = 32'd524;
    localparam logic [39:0] POS_HALF = 40'h7D_0000_0000;

    localparam int TRIG_W    = 31;
    localparam int ROM_DEPTH = 721;
    localparam int ROM_AW    = 10;
    localparam logic [HEAD_W-1:0] HEAD_FULL    = 13'd5760;
    localparam logic [HEAD_W-1:0] HEAD_QUARTER = 13'd1440;
    localparam logic [HEAD_W-1:0] HEAD_HALF    = 13'd2880;
    localparam logic [HEAD_W-1:0] HEAD_3Q      = 13'd4320;
    localparam logic [HEAD_W-1:0] HEAD_EIGHTH  = 13'd720;

    typedef struct packed {
        logic signed [31:0] right_count;
        logic signed [31:0] left_count;
        logic [31:0]        time_ms;
        logic [12:0]        heading_sixteenths;
        logic               clear;
    } odo_in_t;

    typedef struct packed {
        logic signed [31:0] right_speed;
        logic signed [31:0] left_speed;
        logic signed [31:0] mean_speed;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
    } odo_out_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_CLEAR,
        OP_DEN0,
        OP_DEN1,
        OP_DELTA,
        OP_MD,
        OP_MLO,
        OP_MHI,
        OP_SDIV,
        OP_SSTORE,
        OP_MEAN,
        OP_ROM,
        OP_TRIG,
        OP_VT,
        OP_PLO,
        OP_PHI,
        OP_PRND,
        OP_RLL,
        OP_RLH,
        OP_RHL,
        OP_RHH,
        OP_PSTORE,
        OP_PSTAMP,
        OP_HEAD,
        OP_OUT
    } odo_op_t;

    typedef struct packed {
        odo_op_t op;
        logic    sel;
    } odo_cmd_t;

    typedef struct packed {
        logic clear;
        logic spd_dt_zero;
        logic pos_dt_zero;
        logic div_done;
    } odo_status_t;

    function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] p;
        p = a * b + 64'd536870912;
        return p >> 30;
    endfunction

    // Sine and cosine in Q30 of an angle of r/16 degree, r within one octant.
    function automatic logic [2*TRIG_W-1:0] trig_entry(input int unsigned r);
        logic [63:0] one;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] ts;
        logic [63:0] tc;
        logic [63:0] s0;
        logic [63:0] c0;
        one = 64'd1 << 30;
        x   = (64'(r) * 64'(PI_Q30) + 64'd1440) / 64'd2880;
        x2  = qmul(x, x);
        ts  = one - x2 / 64'd72;
        ts  = one - qmul(x2, ts) / 64'd42;
        ts  = one - qmul(x2, ts) / 64'd20;
        ts  = one - qmul(x2, ts) / 64'd6;
        s0  = qmul(x, ts);
        tc  = one - x2 / 64'd90;
        tc  = one - qmul(x2, tc) / 64'd56;
        tc  = one - qmul(x2, tc) / 64'd30;
        tc  = one - qmul(x2, tc) / 64'd12;
        c0  = one - qmul(x2, tc) / 64'd2;
        return {s0[TRIG_W-1:0], c0[TRIG_W-1:0]};
    endfunction

endpackage

// ===== rtl/differential_drive_odometry_core.sv =====
`timescale 1ns / 1ps
// One item at a time: each item posts its result when the output is free, and the
// next item is taken the cycle after the result is posted, so no item is accepted
// before the last one is through. Most of a full update goes to two 34-step
// divisions in the shared restoring divider for the wheel speeds. Reset (aresetn,
// synchronous, active low) zeroes all odometry state and restores the configuration
// defaults.
module differential_drive_odometry_core import odo_pkg::*; #(
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  odo_in_t               s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output odo_out_t              m_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    odo_cmd_t    cmd;
    odo_status_t status;

    odo_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    odo_datapath #(
        .FRAC_BITS   (FRAC_BITS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_data   (s_data),
        .cmd       (cmd),
        .status    (status),
        .out_data  (m_data)
    );

endmodule

// ===== rtl/odo_trig_rom.sv =====
`timescale 1ns / 1ps
module odo_trig_rom import odo_pkg::*; (
    input  logic                    aclk,
    input  logic [ROM_AW-1:0]       rom_addr,
    output logic [2*TRIG_W-1:0]     rom_data
);

    logic [2*TRIG_W-1:0] rom [ROM_DEPTH];
    logic [2*TRIG_W-1:0] rom_data_reg;

    for (genvar g = 0; g < ROM_DEPTH; g++) begin : g_rom
        localparam logic [2*TRIG_W-1:0] ENTRY = trig_entry(g);
        assign rom[g] = ENTRY;
    end

    always_ff @(posedge aclk) begin
        rom_data_reg <= rom[rom_addr];
    end

    assign rom_data = rom_data_reg;

endmodule

// ===== rtl/odo_div.sv =====
`timescale 1ns / 1ps
module odo_div import odo_pkg::*; #(
    parameter int NUM_W = 95,
    parameter int DIV_W = 88
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DIV_W-1:0] den,
    output logic             done,
    output logic [QUO_W-1:0] quo
);

    localparam int HI_W  = NUM_W - QUO_W;
    localparam int CMP_W = (HI_W > DIV_W) ? HI_W : DIV_W;
    localparam int CNT_W = $clog2(QUO_W + 1);

    typedef enum logic [1:0] {DV_IDLE, DV_CHECK, DV_RUN, DV_DONE} dv_state_t;

    dv_state_t        state_reg;
    logic [NUM_W-1:0] num_reg;
    logic [DIV_W-1:0] den_reg;
    logic [DIV_W-1:0] rem_reg;
    logic [QUO_W-1:0] quo_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic [DIV_W:0] trial;
    logic           fits;
    logic           hi_ge;

    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign fits  = trial >= {1'b0, den_reg};
    assign hi_ge = CMP_W'(num_reg[NUM_W-1:QUO_W]) >= CMP_W'(den_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DV_IDLE;
        end else begin
            unique case (state_reg)
                DV_IDLE: begin
                    if (start) begin
                        state_reg <= DV_CHECK;
                    end
                end
                DV_CHECK: begin
                    state_reg <= hi_ge ? DV_DONE : DV_RUN;
                end
                DV_RUN: begin
                    if (cnt_reg == CNT_W'(1)) begin
                        state_reg <= DV_DONE;
                    end
                end
                DV_DONE: begin
                    state_reg <= DV_IDLE;
                end
                default: state_reg <= DV_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            DV_IDLE: begin
                if (start) begin
                    num_reg <= num + NUM_W'(den >> 1);
                    den_reg <= den;
                end
            end
            DV_CHECK: begin
                if (hi_ge) begin
                    quo_reg <= SAT_MAG;
                end else begin
                    rem_reg <= DIV_W'(num_reg[NUM_W-1:QUO_W]);
                    num_reg <= num_reg << HI_W;
                    cnt_reg <= CNT_W'(QUO_W);
                end
            end
            DV_RUN: begin
                rem_reg <= fits ? DIV_W'(trial - {1'b0, den_reg}) : trial[DIV_W-1:0];
                quo_reg <= {quo_reg[QUO_W-2:0], fits};
                num_reg <= num_reg << 1;
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
            default: ;
        endcase
    end

    assign done = (state_reg == DV_DONE);
    assign quo  = (quo_reg > SAT_MAG) ? SAT_MAG : quo_reg;

endmodule

// ===== rtl/odo_datapath.sv =====
`timescale 1ns / 1ps
module odo_datapath import odo_pkg::*; #(
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  odo_in_t               in_data,
    input  odo_cmd_t              cmd,
    output odo_status_t           status,
    output odo_out_t              out_data
);

    localparam int PROD_W = (COUNT_WIDTH + 20 > 62) ? COUNT_WIDTH + 20 : 62;
    localparam int ACC_W  = PROD_W + WORD_W;
    localparam int SP_W   = COUNT_WIDTH + 52 + FRAC_BITS;
    localparam int NUM_W  = ((SP_W > ACC_W) ? SP_W : ACC_W) + 1;
    localparam int DIV_W  = DEN_W + Q30;

    function automatic logic signed [31:0] sat_signed(input logic neg,
                                                      input logic [QUO_W-1:0] mag);
        logic big;
        big = neg ? (mag >= QUO_W'(32'h8000_0000)) : (mag > QUO_W'(32'h7FFF_FFFF));
        if (big) begin
            return neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        return neg ? -$signed(mag[31:0]) : $signed(mag[31:0]);
    endfunction

    logic [15:0]              cpr_reg;
    logic [19:0]              diam_reg;
    logic [COUNT_WIDTH-1:0]   prev_right_reg;
    logic [COUNT_WIDTH-1:0]   prev_left_reg;
    logic [31:0]              speed_stamp_reg;
    logic [31:0]              pos_stamp_reg;
    logic signed [31:0]       spd_r_reg;
    logic signed [31:0]       spd_l_reg;
    logic signed [31:0]       spd_m_reg;
    logic signed [31:0]       x_reg;
    logic signed [31:0]       y_reg;
    logic [HEAD_W-1:0]        heading_reg;

    odo_in_t                  in_reg;
    odo_out_t                 out_reg;
    logic [DEN_W-1:0]         den_reg;
    logic [WORD_W-1:0]        mag_reg;
    logic                     neg_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic [ACC_W-1:0]         acc_reg;
    logic [RX_W-1:0]          rx_reg;
    logic                     psat_reg;
    logic [1:0]               quad_reg;
    logic                     swap_reg;
    logic [TRIG_W-1:0]        tmag_c_reg;
    logic [TRIG_W-1:0]        tmag_s_reg;
    logic                     tneg_c_reg;
    logic                     tneg_s_reg;

    logic [31:0]              spd_dt;
    logic [31:0]              pos_dt;
    logic [COUNT_WIDTH-1:0]   cnt_sel;
    logic [COUNT_WIDTH-1:0]   prev_sel;
    logic [COUNT_WIDTH-1:0]   delta;
    logic [COUNT_WIDTH-1:0]   dmag;
    logic [15:0]              cpr_eff;
    logic [WORD_W-1:0]        mmag;
    logic [WORD_W-1:0]        mul_a;
    logic [WORD_W-1:0]        mul_b;
    logic [63:0]              product;
    logic [HEAD_W-1:0]        h_mod;
    logic [1:0]               quad;
    logic [HEAD_W-1:0]        h_rem;
    logic                     swap;
    logic [HEAD_W-1:0]        r_oct;
    logic [2*TRIG_W-1:0]      rom_data;
    logic [TRIG_W-1:0]        s0;
    logic [TRIG_W-1:0]        c0;
    logic                     div_start;
    logic [NUM_W-1:0]         div_num;
    logic [DIV_W-1:0]         div_den;
    logic                     div_done;
    logic [QUO_W-1:0]         div_quo;
    logic [ACC_W-1:0]         pos_round;
    logic [QUO_W-1:0]         pos_quo;
    logic signed [31:0]       step;
    logic signed [32:0]       pos_sum;
    logic signed [31:0]       pos_old;
    logic signed [31:0]       pos_new;
    logic signed [32:0]       spd_sum;

    assign spd_dt   = in_reg.time_ms - speed_stamp_reg;
    assign pos_dt   = in_reg.time_ms - pos_stamp_reg;
    assign cnt_sel  = cmd.sel ? COUNT_WIDTH'(in_reg.left_count)
                              : COUNT_WIDTH'(in_reg.right_count);
    assign prev_sel = cmd.sel ? prev_left_reg : prev_right_reg;
    assign delta    = cnt_sel - prev_sel;
    assign dmag     = delta[COUNT_WIDTH-1] ? -delta : delta;
    assign cpr_eff  = (cpr_reg == 16'd0) ? 16'd1 : cpr_reg;
    assign mmag     = spd_m_reg[31] ? -spd_m_reg : spd_m_reg;
    assign spd_sum  = 33'(spd_r_reg) + 33'(spd_l_reg);

    assign status.clear       = in_reg.clear;
    assign status.spd_dt_zero = (spd_dt == 32'd0);
    assign status.pos_dt_zero = (pos_dt == 32'd0);
    assign status.div_done    = div_done;

    always_comb begin
        unique case (cmd.op)
            OP_DEN0: begin
                mul_a = WORD_W'(cpr_eff);
                mul_b = spd_dt;
            end
            OP_MD: begin
                mul_a = mag_reg;
                mul_b = WORD_W'(diam_reg);
            end
            OP_MLO: begin
                mul_a = prod_reg[WORD_W-1:0];
                mul_b = PI_Q30;
            end
            OP_MHI: begin
                mul_a = WORD_W'(prod_reg[PROD_W-1:WORD_W]);
                mul_b = PI_Q30;
            end
            OP_VT: begin
                mul_a = mag_reg;
                mul_b = WORD_W'(cmd.sel ? tmag_s_reg : tmag_c_reg);
            end
            OP_PLO: begin
                mul_a = prod_reg[WORD_W-1:0];
                mul_b = pos_dt;
            end
            OP_PHI: begin
                mul_a = WORD_W'(prod_reg[PROD_W-1:WORD_W]);
                mul_b = pos_dt;
            end
            OP_RLL: begin
                mul_a = rx_reg[WORD_W-1:0];
                mul_b = RECIP_LO;
            end
            OP_RLH: begin
                mul_a = rx_reg[WORD_W-1:0];
                mul_b = RECIP_HI;
            end
            OP_RHL: begin
                mul_a = WORD_W'(rx_reg[RX_W-1:WORD_W]);
                mul_b = RECIP_LO;
            end
            OP_RHH: begin
                mul_a = WORD_W'(rx_reg[RX_W-1:WORD_W]);
                mul_b = RECIP_HI;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign product = 64'(mul_a) * 64'(mul_b);

    always_comb begin
        h_mod = (heading_reg >= HEAD_FULL) ? heading_reg - HEAD_FULL : heading_reg;
        priority if (h_mod >= HEAD_3Q) begin
            quad  = 2'd3;
            h_rem = h_mod - HEAD_3Q;
        end else if (h_mod >= HEAD_HALF) begin
            quad  = 2'd2;
            h_rem = h_mod - HEAD_HALF;
        end else if (h_mod >= HEAD_QUARTER) begin
            quad  = 2'd1;
            h_rem = h_mod - HEAD_QUARTER;
        end else begin
            quad  = 2'd0;
            h_rem = h_mod;
        end
        swap  = h_rem > HEAD_EIGHTH;
        r_oct = swap ? HEAD_QUARTER - h_rem : h_rem;
    end

    odo_trig_rom u_rom (
        .aclk     (aclk),
        .rom_addr (r_oct[ROM_AW-1:0]),
        .rom_data (rom_data)
    );

    assign s0 = swap_reg ? rom_data[TRIG_W-1:0] : rom_data[2*TRIG_W-1:TRIG_W];
    assign c0 = swap_reg ? rom_data[2*TRIG_W-1:TRIG_W] : rom_data[TRIG_W-1:0];

    assign div_start = (cmd.op == OP_SDIV);
    assign div_num   = NUM_W'({acc_reg, {FRAC_BITS{1'b0}}});
    assign div_den   = DIV_W'({den_reg, {Q30{1'b0}}});

    odo_div #(
        .NUM_W (NUM_W),
        .DIV_W (DIV_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    // The position step divides by 1000*2^30: a rounding shift by 33 bits, then a
    // multiplication by the reciprocal of 125 scaled by 2^48.
    assign pos_round = acc_reg + ACC_W'(POS_HALF);
    assign pos_quo   = psat_reg ? SAT_MAG : acc_reg[RECIP_SHIFT +: QUO_W];

    assign step    = sat_signed(neg_reg ^ (cmd.sel ? tneg_s_reg : tneg_c_reg), pos_quo);
    assign pos_old = cmd.sel ? y_reg : x_reg;
    assign pos_sum = 33'(pos_old) + 33'(step);
    assign pos_new = (pos_sum[32] != pos_sum[31])
                   ? (pos_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
                   : pos_sum[31:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cpr_reg         <= CPR_RESET;
            diam_reg        <= DIAM_RESET;
            prev_right_reg  <= '0;
            prev_left_reg   <= '0;
            speed_stamp_reg <= '0;
            pos_stamp_reg   <= '0;
            spd_r_reg       <= '0;
            spd_l_reg       <= '0;
            spd_m_reg       <= '0;
            x_reg           <= '0;
            y_reg           <= '0;
            heading_reg     <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_COUNTS_PER_REV:    cpr_reg  <= cfg_wdata[15:0];
                    REG_WHEEL_DIAMETER_UM: diam_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            unique case (cmd.op)
                OP_CLEAR: begin
                    prev_right_reg  <= '0;
                    prev_left_reg   <= '0;
                    speed_stamp_reg <= in_reg.time_ms;
                end
                OP_SSTORE: begin
                    if (cmd.sel) begin
                        spd_l_reg <= sat_signed(~neg_reg, div_quo);
                    end else begin
                        spd_r_reg <= sat_signed(neg_reg, div_quo);
                    end
                end
                OP_MEAN: begin
                    spd_m_reg       <= spd_sum[32:1];
                    prev_right_reg  <= COUNT_WIDTH'(in_reg.right_count);
                    prev_left_reg   <= COUNT_WIDTH'(in_reg.left_count);
                    speed_stamp_reg <= in_reg.time_ms;
                end
                OP_PSTORE: begin
                    if (cmd.sel) begin
                        y_reg <= pos_new;
                    end else begin
                        x_reg <= pos_new;
                    end
                end
                OP_PSTAMP: pos_stamp_reg <= in_reg.time_ms;
                OP_HEAD:   heading_reg   <= in_reg.heading_sixteenths;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            OP_LOAD: in_reg  <= in_data;
            OP_DEN0: den_reg <= DEN_W'(product);
            OP_DEN1: den_reg <= (den_reg << 10) - (den_reg << 4) - (den_reg << 3);
            OP_DELTA: begin
                mag_reg <= WORD_W'(dmag);
                neg_reg <= delta[COUNT_WIDTH-1];
            end
            OP_MD:   prod_reg <= PROD_W'(product);
            OP_MLO:  acc_reg  <= ACC_W'(product);
            OP_MHI:  acc_reg  <= acc_reg + (ACC_W'(product) << WORD_W);
            OP_ROM: begin
                quad_reg <= quad;
                swap_reg <= swap;
                mag_reg  <= mmag;
                neg_reg  <= spd_m_reg[31];
            end
            OP_TRIG: begin
                unique case (quad_reg)
                    2'd0: begin
                        tmag_c_reg <= c0; tneg_c_reg <= 1'b0;
                        tmag_s_reg <= s0; tneg_s_reg <= 1'b0;
                    end
                    2'd1: begin
                        tmag_c_reg <= s0; tneg_c_reg <= 1'b1;
                        tmag_s_reg <= c0; tneg_s_reg <= 1'b0;
                    end
                    2'd2: begin
                        tmag_c_reg <= c0; tneg_c_reg <= 1'b1;
                        tmag_s_reg <= s0; tneg_s_reg <= 1'b1;
                    end
                    default: begin
                        tmag_c_reg <= s0; tneg_c_reg <= 1'b0;
                        tmag_s_reg <= c0; tneg_s_reg <= 1'b1;
                    end
                endcase
            end
            OP_VT:  prod_reg <= PROD_W'(product);
            OP_PLO: acc_reg  <= ACC_W'(product);
            OP_PHI: acc_reg  <= acc_reg + (ACC_W'(product) << WORD_W);
            OP_PRND: begin
                rx_reg   <= pos_round[Q30+3 +: RX_W];
                psat_reg <= |pos_round[ACC_W-1:Q30+3+RX_W];
            end
            OP_RLL:         acc_reg <= ACC_W'(product);
            OP_RLH, OP_RHL: acc_reg <= acc_reg + (ACC_W'(product) << WORD_W);
            OP_RHH:         acc_reg <= acc_reg + (ACC_W'(product) << (2*WORD_W));
            OP_OUT: begin
                out_reg.right_speed <= spd_r_reg;
                out_reg.left_speed  <= spd_l_reg;
                out_reg.mean_speed  <= spd_m_reg;
                out_reg.pos_x       <= x_reg;
                out_reg.pos_y       <= y_reg;
            end
            default: ;
        endcase
    end

    assign out_data = out_reg;

endmodule

// ===== rtl/odo_ctrl.sv =====
`timescale 1ns / 1ps
module odo_ctrl import odo_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    output logic        m_valid,
    input  logic        m_ready,
    input  odo_status_t status,
    output odo_cmd_t    cmd
);

    typedef enum logic [4:0] {
        C_IDLE, C_DECIDE, C_CLEAR, C_DEN0, C_DEN1, C_DELTA, C_MD, C_MLO, C_MHI,
        C_SDIV, C_SWAIT, C_SSTORE, C_MEAN, C_POSCHK, C_ROM, C_TRIG, C_VT, C_PLO,
        C_PHI, C_PRND, C_RLL, C_RLH, C_RHL, C_RHH, C_PSTORE, C_PSTAMP, C_HEAD,
        C_FINISH
    } ctrl_state_t;

    ctrl_state_t state_reg;
    logic        sel_reg;
    logic        m_valid_reg;
    logic        out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == C_IDLE);
    assign m_valid  = m_valid_reg;
    assign cmd.sel  = sel_reg;

    always_comb begin
        unique case (state_reg)
            C_IDLE:   cmd.op = s_valid ? OP_LOAD : OP_NONE;
            C_CLEAR:  cmd.op = OP_CLEAR;
            C_DEN0:   cmd.op = OP_DEN0;
            C_DEN1:   cmd.op = OP_DEN1;
            C_DELTA:  cmd.op = OP_DELTA;
            C_MD:     cmd.op = OP_MD;
            C_MLO:    cmd.op = OP_MLO;
            C_MHI:    cmd.op = OP_MHI;
            C_SDIV:   cmd.op = OP_SDIV;
            C_SSTORE: cmd.op = OP_SSTORE;
            C_MEAN:   cmd.op = OP_MEAN;
            C_ROM:    cmd.op = OP_ROM;
            C_TRIG:   cmd.op = OP_TRIG;
            C_VT:     cmd.op = OP_VT;
            C_PLO:    cmd.op = OP_PLO;
            C_PHI:    cmd.op = OP_PHI;
            C_PRND:   cmd.op = OP_PRND;
            C_RLL:    cmd.op = OP_RLL;
            C_RLH:    cmd.op = OP_RLH;
            C_RHL:    cmd.op = OP_RHL;
            C_RHH:    cmd.op = OP_RHH;
            C_PSTORE: cmd.op = OP_PSTORE;
            C_PSTAMP: cmd.op = OP_PSTAMP;
            C_HEAD:   cmd.op = OP_HEAD;
            C_FINISH: cmd.op = out_free ? OP_OUT : OP_NONE;
            default:  cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= C_IDLE;
            sel_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (state_reg == C_FINISH && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                C_IDLE: begin
                    if (s_valid) begin
                        state_reg <= C_DECIDE;
                    end
                end
                C_DECIDE: begin
                    sel_reg <= 1'b0;
                    priority if (status.clear) begin
                        state_reg <= C_CLEAR;
                    end else if (status.spd_dt_zero) begin
                        state_reg <= C_POSCHK;
                    end else begin
                        state_reg <= C_DEN0;
                    end
                end
                C_CLEAR: state_reg <= C_FINISH;
                C_DEN0:  state_reg <= C_DEN1;
                C_DEN1:  state_reg <= C_DELTA;
                C_DELTA: state_reg <= C_MD;
                C_MD:    state_reg <= C_MLO;
                C_MLO:   state_reg <= C_MHI;
                C_MHI:   state_reg <= C_SDIV;
                C_SDIV:  state_reg <= C_SWAIT;
                C_SWAIT: begin
                    if (status.div_done) begin
                        state_reg <= C_SSTORE;
                    end
                end
                C_SSTORE: begin
                    if (sel_reg) begin
                        sel_reg   <= 1'b0;
                        state_reg <= C_MEAN;
                    end else begin
                        sel_reg   <= 1'b1;
                        state_reg <= C_DELTA;
                    end
                end
                C_MEAN: state_reg <= C_POSCHK;
                C_POSCHK: begin
                    sel_reg   <= 1'b0;
                    state_reg <= status.pos_dt_zero ? C_HEAD : C_ROM;
                end
                C_ROM:   state_reg <= C_TRIG;
                C_TRIG:  state_reg <= C_VT;
                C_VT:    state_reg <= C_PLO;
                C_PLO:   state_reg <= C_PHI;
                C_PHI:   state_reg <= C_PRND;
                C_PRND:  state_reg <= C_RLL;
                C_RLL:   state_reg <= C_RLH;
                C_RLH:   state_reg <= C_RHL;
                C_RHL:   state_reg <= C_RHH;
                C_RHH:   state_reg <= C_PSTORE;
                C_PSTORE: begin
                    if (sel_reg) begin
                        sel_reg   <= 1'b0;
                        state_reg <= C_PSTAMP;
                    end else begin
                        sel_reg   <= 1'b1;
                        state_reg <= C_VT;
                    end
                end
                C_PSTAMP: state_reg <= C_HEAD;
                C_HEAD:   state_reg <= C_FINISH;
                C_FINISH: begin
                    if (out_free) begin
                        state_reg <= C_IDLE;
                    end
                end
                default: state_reg <= C_IDLE;
            endcase
        end
    end

endmodule

// ===== test/differential_drive_odometry_checker.sv =====
`timescale 1ns / 1ps
module differential_drive_odometry_checker import odo_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  odo_in_t               s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  odo_out_t              m_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                    errors,
    output int                    pending,
    output int                    results_seen
);

    localparam logic [63:0] PI_FIX = 64'd3373259426;
    localparam logic [63:0] ONE_FIX = 64'd1 << 30;
    localparam logic [127:0] MAG_CAP = 128'h2_0000_0000;

    logic [15:0] cpr;
    logic [19:0] diam;
    logic [31:0] last_right, last_left, speed_time, pos_time;
    longint      right_v, left_v, mean_v, x_pos, y_pos;
    logic [12:0] heading_held;
    odo_out_t    expected_q[$];

    function automatic logic [33:0] round_div(logic [127:0] n, logic [127:0] d);
        logic [127:0] q;
        q = (n + (d >> 1)) / d;
        if (q > MAG_CAP) q = MAG_CAP;
        return q[33:0];
    endfunction

    function automatic longint clamp_word(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint apply_sign(bit neg, logic [33:0] mag);
        longint m;
        m = longint'({30'd0, mag});
        return clamp_word(neg ? -m : m);
    endfunction

    function automatic longint wheel_rate(logic [31:0] cnt, logic [31:0] prev,
                                          logic [31:0] dt, bit negate);
        logic [31:0]  d;
        logic [31:0]  mag;
        logic [127:0] n;
        logic [127:0] den;
        logic [15:0]  c;
        d   = cnt - prev;
        mag = d[31] ? -d : d;
        c   = (cpr == 16'd0) ? 16'd1 : cpr;
        n   = (128'(mag) * 128'(diam) * 128'(PI_FIX)) << 16;
        den = (128'(c) * 128'(dt) * 128'd1000) << 30;
        return apply_sign(d[31] != negate, round_div(n, den));
    endfunction

    function automatic logic [63:0] fix_mul(logic [63:0] a, logic [63:0] b);
        logic [63:0] p;
        p = a * b + (ONE_FIX >> 1);
        return p >> 30;
    endfunction

    function automatic void heading_trig(logic [12:0] h, output longint c, output longint s);
        logic [63:0] hh, q, r, x, x2, ts, tc, s0, c0, t;
        hh = 64'(h) % 64'd5760;
        q  = hh / 64'd1440;
        r  = hh % 64'd1440;
        t  = 0;
        if (r > 64'd720) begin
            r = 64'd1440 - r;
            t = 1;
        end
        x  = (r * PI_FIX + 64'd1440) / 64'd2880;
        x2 = fix_mul(x, x);
        ts = ONE_FIX - x2 / 64'd72;
        ts = ONE_FIX - fix_mul(x2, ts) / 64'd42;
        ts = ONE_FIX - fix_mul(x2, ts) / 64'd20;
        ts = ONE_FIX - fix_mul(x2, ts) / 64'd6;
        s0 = fix_mul(x, ts);
        tc = ONE_FIX - x2 / 64'd90;
        tc = ONE_FIX - fix_mul(x2, tc) / 64'd56;
        tc = ONE_FIX - fix_mul(x2, tc) / 64'd30;
        tc = ONE_FIX - fix_mul(x2, tc) / 64'd12;
        c0 = ONE_FIX - fix_mul(x2, tc) / 64'd2;
        if (t != 0) begin
            t  = s0;
            s0 = c0;
            c0 = t;
        end
        case (q)
            64'd0: begin c = longint'(c0); s = longint'(s0); end
            64'd1: begin c = -longint'(s0); s = longint'(c0); end
            64'd2: begin c = -longint'(c0); s = -longint'(s0); end
            default: begin c = longint'(s0); s = -longint'(c0); end
        endcase
    endfunction

    function automatic longint position_step(longint v, longint t, logic [31:0] dt);
        logic [63:0] mv, mt;
        mv = (v < 0) ? -v : v;
        mt = (t < 0) ? -t : t;
        return apply_sign((v < 0) != (t < 0),
                          round_div(128'(mv * mt) * 128'(dt), 128'd1000 << 30));
    endfunction

    function automatic odo_out_t odometry_update(odo_in_t it);
        logic [31:0] dt;
        longint      c, s;
        odo_out_t    o;
        if (it.clear) begin
            last_right = 0;
            last_left  = 0;
            speed_time = it.time_ms;
        end else begin
            dt = it.time_ms - speed_time;
            if (dt != 0) begin
                right_v    = wheel_rate(it.right_count, last_right, dt, 1'b0);
                left_v     = wheel_rate(it.left_count, last_left, dt, 1'b1);
                mean_v     = (right_v + left_v) >>> 1;
                last_right = it.right_count;
                last_left  = it.left_count;
                speed_time = it.time_ms;
            end
            dt = it.time_ms - pos_time;
            if (dt != 0) begin
                heading_trig(heading_held, c, s);
                x_pos    = clamp_word(x_pos + position_step(mean_v, c, dt));
                y_pos    = clamp_word(y_pos + position_step(mean_v, s, dt));
                pos_time = it.time_ms;
            end
            heading_held = it.heading_sixteenths;
        end
        o.right_speed = right_v[31:0];
        o.left_speed  = left_v[31:0];
        o.mean_speed  = mean_v[31:0];
        o.pos_x       = x_pos[31:0];
        o.pos_y       = y_pos[31:0];
        return o;
    endfunction

    initial begin
        errors       = 0;
        pending      = 0;
        results_seen = 0;
    end

    always @(posedge aclk) begin
        odo_out_t want;
        if (!aresetn) begin
            cpr          = CPR_RESET;
            diam         = DIAM_RESET;
            last_right   = 0;
            last_left    = 0;
            speed_time   = 0;
            pos_time     = 0;
            right_v      = 0;
            left_v       = 0;
            mean_v       = 0;
            x_pos        = 0;
            y_pos        = 0;
            heading_held = 0;
            expected_q.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_COUNTS_PER_REV) cpr = cfg_wdata[15:0];
                else if (cfg_index == REG_WHEEL_DIAMETER_UM) diam = cfg_wdata;
            end
            if (s_valid && s_ready) expected_q.push_back(odometry_update(s_data));
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("Unexpected result item %h", m_data);
                end else begin
                    want = expected_q.pop_front();
                    if (want.right_speed != m_data.right_speed ||
                        want.left_speed != m_data.left_speed ||
                        want.mean_speed != m_data.mean_speed ||
                        want.pos_x != m_data.pos_x || want.pos_y != m_data.pos_y) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("Mismatch on result %0d (right left mean x y):",
                                     results_seen);
                            $display("  expected %h %h %h %h %h", want.right_speed,
                                     want.left_speed, want.mean_speed, want.pos_x, want.pos_y);
                            $display("  actual   %h %h %h %h %h", m_data.right_speed,
                                     m_data.left_speed, m_data.mean_speed, m_data.pos_x,
                                     m_data.pos_y);
                        end
                    end
                end
            end
        end
        pending = expected_q.size();
    end

endmodule

// ===== test/differential_drive_odometry_core_tb.sv =====
`timescale 1ns / 1ps
module differential_drive_odometry_core_tb;
    import odo_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    logic                  aclk = 0;
    logic                  aresetn = 0;
    logic                  s_valid = 0;
    logic                  s_ready;
    odo_in_t               s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 0;
    odo_out_t              m_data;
    logic                  cfg_we = 0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_COUNTS_PER_REV;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int          errors, pending, results_seen;
    int          cycles = 0;
    int          items_sent = 0;
    int          settings_used = 0;
    bit          steady = 0;
    logic [31:0] run_right = 0, run_left = 0, run_time = 0;

    differential_drive_odometry_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    differential_drive_odometry_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .errors(errors), .pending(pending), .results_seen(results_seen)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL differential_drive_odometry_core");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(99) >= 14);
    end

    task automatic send_sample(odo_in_t it);
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        if (!steady && $urandom_range(99) < 14) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    task automatic drain;
        if (s_valid) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic odo_in_t make_sample(logic [31:0] r, logic [31:0] l, logic [31:0] t,
                                            logic [12:0] h, logic c);
        odo_in_t it;
        it.right_count        = r;
        it.left_count         = l;
        it.time_ms            = t;
        it.heading_sixteenths = h;
        it.clear              = c;
        return it;
    endfunction

    function automatic odo_in_t random_sample();
        int roll;
        roll = $urandom_range(99);
        if (roll < 80) begin
            run_right = run_right + $urandom_range(4000) - 2000;
            run_left  = run_left + $urandom_range(4000) - 2000;
            if ($urandom_range(99) >= 6) run_time = run_time + $urandom_range(1, 40);
            return make_sample(run_right, run_left, run_time,
                               13'($urandom_range(5759)), $urandom_range(99) < 5);
        end
        run_time = $urandom;
        return make_sample($urandom, $urandom, run_time, 13'($urandom), $urandom_range(1));
    endfunction

    initial begin
        logic [15:0] cpr_set[5];
        logic [19:0] diam_set[5];
        logic [12:0] angles[8];
        cpr_set  = '{16'd910, 16'd1, 16'd65535, 16'd0, 16'd4096};
        diam_set = '{20'd67000, 20'd1000000, 20'd1, 20'd1048575, 20'd123456};
        angles   = '{13'd1440, 13'd2880, 13'd4320, 13'd720, 13'd721, 13'd719, 13'd5759,
                     13'd8191};

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_sample(make_sample(32'd5, 32'd5, 32'd0, 13'd0, 1'b0));
        send_sample(make_sample(32'd100, -32'd100, 32'd20, 13'd0, 1'b0));
        send_sample(make_sample(32'd300, 32'd0, 32'd20, 13'd100, 1'b0));
        send_sample(make_sample(32'h7fffffff, 32'h80000000, 32'd40, 13'd5759, 1'b0));
        send_sample(make_sample(32'h80000000, 32'h7fffffff, 32'd41, 13'd8191, 1'b0));
        send_sample(make_sample(32'd9, 32'd9, 32'd70, 13'd200, 1'b1));
        send_sample(make_sample(32'd50, -32'd50, 32'd70, 13'd300, 1'b0));
        foreach (angles[i])
            send_sample(make_sample(32'd60 + i * 40, -32'd60 - i * 40, 32'd80 + i,
                                    angles[i], 1'b0));
        send_sample(make_sample(32'hffffffff, 32'h0, 32'hfffffff0, 13'd0, 1'b0));
        send_sample(make_sample(32'h0, 32'hffffffff, 32'd5, 13'd1000, 1'b0));
        send_sample(make_sample(32'h0, 32'h0, 32'hffffffff, 13'd0, 1'b0));
        send_sample(make_sample(32'h0, 32'h0, 32'd0, 13'd0, 1'b1));

        foreach (cpr_set[p]) begin
            drain();
            write_reg(REG_COUNTS_PER_REV, CFG_DATA_W'(cpr_set[p]));
            write_reg(REG_WHEEL_DIAMETER_UM, diam_set[p]);
            settings_used++;
            for (int k = 0; k < 120; k++) begin
                steady = (p == 2 && k >= 20 && k < 80);
                if (p == 1 && k == 60) drain();
                send_sample(random_sample());
            end
            steady = 0;
        end
        drain();

        $display("Sent %0d samples (directed edge cases, then random) over %0d settings;",
                 items_sent, settings_used);
        $display("%0d results checked, including clears, zero dt and saturation.",
                 results_seen);
        if (errors == 0 && pending == 0) begin
            $display("PASS differential_drive_odometry_core");
        end else begin
            $display("FAIL differential_drive_odometry_core");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/odo_pkg.sv
rtl/odo_trig_rom.sv
rtl/odo_div.sv
rtl/odo_datapath.sv
rtl/odo_ctrl.sv
rtl/differential_drive_odometry_core.sv
test/differential_drive_odometry_checker.sv
test/differential_drive_odometry_core_tb.sv
